// ===== rtl/swti_pkg.sv =====
package swti_pkg;

    // One stored word: 20 bytes, first byte most significant.
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid;
        logic [31:0] lo;
    } t_word;

    // Result of comparing a stored entry against the search key.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    // Request kinds.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_READ_OK   = 3'd3;
    localparam logic [2:0] ST_BEYOND    = 3'd4;

endpackage

// ===== rtl/swti_mem.sv =====
module swti_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  swti_pkg::t_word      i_wr_data,
    input  logic [AW-1:0]        i_rd_addr,
    output swti_pkg::t_word      o_rd_data
);
    import swti_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Single read port with registered data, read every cycle.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/swti_cmp.sv =====
module swti_cmp (
    input  swti_pkg::t_word i_entry,
    input  swti_pkg::t_word i_key,
    output swti_pkg::t_cmp  o_res
);
    import swti_pkg::*;

    // Bytewise lexicographic order equals unsigned order of the packed word.
    always_comb begin
        o_res.lt = (i_entry < i_key);
        o_res.eq = (i_entry == i_key);
    end

endmodule

// ===== rtl/sorted_word_table_insert_top.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// request   | i_in_valid / o_in_ready    | i_action i_index i_word_hi i_word_mid i_word_lo
// result    | o_out_valid / i_out_ready  | o_status o_position o_out_hi o_out_mid o_out_lo
//           |                            | o_entry_count
//
// A read passes through the read-data state to the result; a read beyond the count goes straight to it.
// An insert runs a binary search, each step one memory read and one compare,
// then moves every entry at or above the insert point up one place through the
// single-port shift; setup, search exit, shift exit, word write and result load
// are further steps. A duplicate or a full table skips the shift and the write.
// The table memory needs no clearing pass after reset; only the count is cleared.
// A finished result waits in the output register while the next request is taken.
module sorted_word_table_insert_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [6:0]  i_index,
    input  logic [63:0] i_word_hi,
    input  logic [63:0] i_word_mid,
    input  logic [31:0] i_word_lo,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [6:0]  o_position,
    output logic [63:0] o_out_hi,
    output logic [63:0] o_out_mid,
    output logic [31:0] o_out_lo,
    output logic [7:0]  o_entry_count
);
    import swti_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_DATA,
        S_PROBE,
        S_COMPARE,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_mid;
    logic [CW-1:0] r_dst;
    logic          r_found;
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    t_word         r_key;
    t_word         r_rdword;
    logic [2:0]    r_res_status;
    logic [6:0]    r_res_pos;
    logic          r_o_valid;

    t_word           w_rd_data;
    logic [AW-1:0]   w_rd_addr;
    logic            w_wr_en;
    logic [AW-1:0]   w_wr_addr;
    t_word           w_wr_data;
    t_cmp            w_cmp;
    logic [CW-1:0]   w_mid;
    logic [CW+6:0]   w_idx_ext;
    logic [CW+6:0]   w_cnt_ext;
    logic [CW+6:0]   w_lo_ext;
    logic [CW+7:0]   w_cnt_out;
    logic            w_out_free;

    swti_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    swti_cmp u_cmp (
        .i_entry (w_rd_data),
        .i_key   (r_key),
        .o_res   (w_cmp)
    );

    // Width adapters between the request fields and the table counters.
    assign w_idx_ext  = {{CW{1'b0}}, i_index};
    assign w_cnt_ext  = {7'd0, r_count};
    assign w_lo_ext   = {7'd0, r_lo};
    assign w_cnt_out  = {8'd0, r_count};
    assign w_mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign w_out_free = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Memory address and write selection for the current step.
    always_comb begin
        w_rd_addr = r_mid[AW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_pend_addr;
        w_wr_data = w_rd_data;
        case (r_state)
            S_IDLE: begin
                w_rd_addr = w_idx_ext[AW-1:0];
            end
            S_PROBE: begin
                w_rd_addr = w_mid[AW-1:0];
            end
            S_SHIFT: begin
                w_rd_addr = r_dst[AW-1:0] - AW'(1);
                w_wr_en   = r_pend;
            end
            S_WRITE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_lo[AW-1:0];
                w_wr_data = r_key;
            end
            default: begin
                w_rd_addr = r_mid[AW-1:0];
            end
        endcase
    end

    // Sequencer: reads, search, shift, write, and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            // A result taken while no new one is loaded leaves the register empty.
            if (r_o_valid && i_out_ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key     <= '{hi: i_word_hi, mid: i_word_mid, lo: i_word_lo};
                        r_res_pos <= i_index;
                        r_rdword  <= '0;
                        if (i_action == ACT_READ) begin
                            if (w_idx_ext < w_cnt_ext) begin
                                r_res_status <= ST_READ_OK;
                                r_state      <= S_RD_DATA;
                            end else begin
                                r_res_status <= ST_BEYOND;
                                r_state      <= S_DONE;
                            end
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= r_count;
                            r_found <= 1'b0;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_RD_DATA: begin
                    r_rdword <= w_rd_data;
                    r_state  <= S_DONE;
                end
                S_PROBE: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_COMPARE;
                    end else begin
                        r_res_pos <= w_lo_ext[6:0];
                        if (r_found) begin
                            r_res_status <= ST_DUPLICATE;
                            r_state      <= S_DONE;
                        end else if (r_count == CW'(TABLE_DEPTH)) begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_DONE;
                        end else begin
                            r_dst   <= r_count;
                            r_pend  <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_COMPARE: begin
                    // Entries are unique, so an equal probe marks the lower bound.
                    if (w_cmp.lt) begin
                        r_lo <= r_mid + CW'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    if (w_cmp.eq) begin
                        r_found <= 1'b1;
                    end
                    r_state <= S_PROBE;
                end
                S_SHIFT: begin
                    // Read entry dst-1 now; its data lands at dst next cycle.
                    if (r_dst > r_lo) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_dst[AW-1:0];
                        r_dst       <= r_dst - CW'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_count      <= r_count + CW'(1);
                    r_res_status <= ST_INSERTED;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        o_status      <= r_res_status;
                        o_position    <= r_res_pos;
                        o_out_hi      <= r_rdword.hi;
                        o_out_mid     <= r_rdword.mid;
                        o_out_lo      <= r_rdword.lo;
                        o_entry_count <= w_cnt_out[7:0];
                        r_o_valid     <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_o_valid;

endmodule

// ===== verif/tb_sorted_word_table_insert_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_word_table_insert_top;

    import swti_pkg::*;

    localparam int TABLE_DEPTH = 128;

    // One result as the table should produce it.
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] position;
        t_word      word;
        logic [7:0] count;
    } t_answer;

    // Flavors of generated words, chosen to reach deep into the compare chain.
    typedef enum int {
        WK_RANDOM,
        WK_SHORT_TEXT,
        WK_NEAR_ENTRY,
        WK_CORNER_PREFIX
    } t_word_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_action;
    logic [6:0]  i_index;
    logic [63:0] i_word_hi;
    logic [63:0] i_word_mid;
    logic [31:0] i_word_lo;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_status;
    logic [6:0]  o_position;
    logic [63:0] o_out_hi;
    logic [63:0] o_out_mid;
    logic [31:0] o_out_lo;
    logic [7:0]  o_entry_count;

    // Shadow copy of the sorted table and the results still owed by the block.
    t_word   shadow_words [TABLE_DEPTH];
    int      shadow_count;
    t_answer answer_q [$];

    int n_errors;
    int n_checked;
    int n_requests;
    int n_stored;
    int n_dups;
    int n_full;
    int n_reads_ok;
    int n_beyond;

    bit src_idle_en;
    bit sink_idle_en;
    int sink_hold_cycles;

    sorted_word_table_insert_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_index      (i_index),
        .i_word_hi    (i_word_hi),
        .i_word_mid   (i_word_mid),
        .i_word_lo    (i_word_lo),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_out_hi     (o_out_hi),
        .o_out_mid    (o_out_mid),
        .o_out_lo     (o_out_lo),
        .o_entry_count(o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the result it must give.
    function automatic t_answer search_and_insert(input logic act, input logic [6:0] idx,
                                                  input t_word w);
        t_answer a;
        int lo;
        int hi;
        int mid;
        a = '0;
        if (act == ACT_READ) begin
            a.position = idx;
            if (int'(idx) < shadow_count) begin
                a.status = ST_READ_OK;
                a.word   = shadow_words[idx];
            end else begin
                a.status = ST_BEYOND;
            end
        end else begin
            // Lower bound: first entry that is not below the word.
            lo = 0;
            hi = shadow_count;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (shadow_words[mid] < w) lo = mid + 1;
                else hi = mid;
            end
            a.position = 7'(lo);
            if (lo < shadow_count && shadow_words[lo] == w) begin
                a.status = ST_DUPLICATE;
            end else if (shadow_count >= TABLE_DEPTH) begin
                a.status = ST_FULL;
            end else begin
                for (int i = shadow_count; i > lo; i--) shadow_words[i] = shadow_words[i - 1];
                shadow_words[lo] = w;
                shadow_count++;
                a.status = ST_INSERTED;
            end
        end
        a.count = 8'(shadow_count);
        return a;
    endfunction

    // Build a zero-padded word from text, first character in the top byte.
    function automatic t_word text_word(input string s);
        logic [159:0] v;
        v = '0;
        for (int b = 0; b < s.len() && b < 20; b++) v[159 - 8 * b -: 8] = s[b];
        return t_word'(v);
    endfunction

    function automatic t_word random_word();
        t_word        w;
        logic [159:0] v;
        int           len;
        w = t_word'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case (t_word_kind'($urandom_range(3)))
            WK_SHORT_TEXT: begin
                // Tiny alphabet so that words share long prefixes.
                v   = '0;
                len = $urandom_range(20, 1);
                for (int b = 0; b < len; b++) v[159 - 8 * b -: 8] = 8'(8'h61 + $urandom_range(2));
                w = t_word'(v);
            end
            WK_NEAR_ENTRY: begin
                if (shadow_count > 0) begin
                    w = shadow_words[$urandom_range(shadow_count - 1)];
                    if ($urandom_range(1)) w.lo = w.lo ^ (32'd1 << $urandom_range(31));
                    else w.mid = {$urandom, $urandom};
                end
            end
            WK_CORNER_PREFIX: begin
                w.hi = $urandom_range(1) ? '1 : 64'($urandom_range(3));
            end
            default: ;
        endcase
        return w;
    endfunction

    // Offer one request, hold it until accepted and record the result it owes.
    task automatic send_request(input logic act, input logic [6:0] idx, input t_word w);
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < 17);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        i_word_hi  <= w.hi;
        i_word_mid <= w.mid;
        i_word_lo  <= w.lo;
        do @(posedge i_clk); while (!o_in_ready);
        answer_q.push_back(search_and_insert(act, idx, w));
        n_requests++;
        case (answer_q[$].status)
            ST_INSERTED:  n_stored++;
            ST_DUPLICATE: n_dups++;
            ST_FULL:      n_full++;
            ST_READ_OK:   n_reads_ok++;
            default:      n_beyond++;
        endcase
    endtask

    // Drop the request line and wait for every owed result.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        int         pick;
        logic [6:0] idx;
        pick = $urandom_range(99);
        idx  = 7'($urandom_range(127));
        if (pick < 20 || (pick < 40 && shadow_count == 0)) begin
            send_request(ACT_INSERT, idx, random_word());
        end else if (pick < 40) begin
            send_request(ACT_INSERT, idx, shadow_words[$urandom_range(shadow_count - 1)]);
        end else begin
            if (shadow_count > 0 && $urandom_range(3) != 0)
                idx = 7'($urandom_range(shadow_count - 1));
            send_request(ACT_READ, idx, random_word());
        end
    endtask

    // Extremes of the fields, ordering across each word part, duplicates and reads.
    task automatic test_directed_edges();
        send_request(ACT_READ, 7'd0, random_word());
        send_request(ACT_READ, 7'h7F, random_word());
        send_request(ACT_INSERT, 7'd0, t_word'('0));
        send_request(ACT_INSERT, 7'h7F, t_word'('0));
        send_request(ACT_INSERT, 7'd0, t_word'({64'hFFFF_FFFF_FFFF_FFFF,
                                                64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFE}));
        send_request(ACT_INSERT, 7'd0, t_word'({64'h0, 64'h0, 32'h1}));
        send_request(ACT_INSERT, 7'd0, t_word'({64'h0, 64'h1, 32'h0}));
        send_request(ACT_INSERT, 7'd0, t_word'({64'h1, 64'h0, 32'h0}));
        send_request(ACT_INSERT, 7'd0, t_word'({64'h0, 64'h1, 32'h0}));
        send_request(ACT_INSERT, 7'd0, text_word("apple"));
        send_request(ACT_INSERT, 7'd0, text_word("apples"));
        send_request(ACT_INSERT, 7'd0, text_word("applesauce_and_more_"));
        send_request(ACT_INSERT, 7'd0, text_word("applesauce_and_more_"));
        // Top bit set must sort above everything that starts lower.
        send_request(ACT_INSERT, 7'd0, t_word'({64'h8000_0000_0000_0000, 64'h0, 32'h0}));
        send_request(ACT_INSERT, 7'd0, t_word'({64'h7FFF_FFFF_FFFF_FFFF,
                                                64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF}));
        for (int k = 0; k < shadow_count; k++) send_request(ACT_READ, 7'(k), random_word());
        send_request(ACT_READ, 7'(shadow_count), random_word());
    endtask

    // The result side stops for a long time while requests keep coming.
    task automatic test_output_stall();
        sink_hold_cycles = 400;
        repeat (10) random_request();
    endtask

    task automatic test_random_mix(input int n);
        repeat (n) random_request();
    endtask

    task automatic test_no_idle_burst(input int n);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_mix(n);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // The request side waits for the block to go fully idle, then resumes.
    task automatic test_sender_pause();
        wait_drained();
        repeat ($urandom_range(30, 5)) @(posedge i_clk);
        test_random_mix(20);
    endtask

    // Fill the table, then probe rejection, duplicate priority and position wrap.
    task automatic test_full_table();
        while (shadow_count < TABLE_DEPTH)
            send_request(ACT_INSERT, 7'($urandom_range(127)), random_word());
        send_request(ACT_INSERT, 7'h7F, shadow_words[0]);
        send_request(ACT_INSERT, 7'd0, shadow_words[TABLE_DEPTH - 1]);
        send_request(ACT_INSERT, 7'd0, t_word'('1));
        send_request(ACT_INSERT, 7'd0, t_word'('0));
        send_request(ACT_INSERT, 7'd0, random_word());
        send_request(ACT_READ, 7'h7F, random_word());
        send_request(ACT_READ, 7'd0, random_word());
        test_random_mix(60);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Result ready control: long hold when asked, else random gaps.
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else if (sink_idle_en) begin
            i_out_ready <= ($urandom_range(99) >= 17);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest owed one.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d position %0d",
                         $time, o_status, o_position);
                n_errors++;
            end else begin
                want = answer_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("position", want.position, o_position);
                check_field("out_hi", want.word.hi, o_out_hi);
                check_field("out_mid", want.word.mid, o_out_mid);
                check_field("out_lo", want.word.lo, o_out_lo);
                check_field("entry_count", want.count, o_entry_count);
                n_checked++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_action         = ACT_INSERT;
        i_index          = '0;
        i_word_hi        = '0;
        i_word_mid       = '0;
        i_word_lo        = '0;
        i_out_ready      = 1'b0;
        src_idle_en      = 1'b1;
        sink_idle_en     = 1'b1;
        sink_hold_cycles = 0;
        shadow_count     = 0;
        foreach (shadow_words[k]) shadow_words[k] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_output_stall();
        test_random_mix(450);
        test_no_idle_burst(150);
        test_sender_pause();
        test_random_mix(430);
        test_full_table();

        // Drain, then allow one full insert time for any stray result.
        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Covered %0d requests: %0d stored, %0d duplicates, %0d rejected on a full table.",
                 n_requests, n_stored, n_dups, n_full);
        $display("Reads: %0d within the table, %0d past the count; %0d results checked, %0d entries.",
                 n_reads_ok, n_beyond, n_checked, shadow_count);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
